FILE: design/ycg_pkg.sv
package ycg_pkg;

  // Fixed field widths of the channels.
  localparam int LUMA_W   = 8;
  localparam int CHROMA_W = 8;
  localparam int ROW_W    = 11;
  localparam int COL_W    = 8;
  localparam int LEVEL_W  = 8;
  localparam int RGB_W    = 24;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 12;

  // Conversion constants (fixed point, 10 fractional bits).
  localparam int K_Y      = 1192;
  localparam int K_RV     = 1634;
  localparam int K_GV     = 833;
  localparam int K_GU     = 400;
  localparam int K_BU     = 2066;
  localparam int Y_OFFSET = 16;
  localparam int C_OFFSET = 128;
  localparam int CHAN_W   = 18;
  localparam int CHAN_MAX = 262143;
  localparam int CONV_W   = 22;
  localparam int GLYPH_MAX = 256;

  typedef enum logic [CFG_IW-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_GRID_ROWS    = 3'd2,
    REG_GRID_COLS    = 3'd3,
    REG_GLYPH_COUNT  = 3'd4,
    REG_ANSI_MODE    = 3'd5
  } ycg_reg_t;

  localparam int REG_COUNT = 6;

  typedef enum logic [2:0] {
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_IDLE,
    ST_PROD,
    ST_MIX,
    ST_ACC,
    ST_FINISH
  } ycg_state_t;

  typedef enum logic [2:0] {
    JOB_W,
    JOB_H,
    JOB_L,
    JOB_R,
    JOB_G,
    JOB_B
  } ycg_job_t;

  typedef struct packed {
    logic     in_ready;
    logic     accept;
    logic     prod;
    logic     mix;
    logic     acc;
    logic     div_start;
    logic     div_store;
    ycg_job_t job;
    logic     finish_load;
  } ycg_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic cfg_restart;
    logic emit;
    logic div_done;
    logic out_free;
  } ycg_status_t;

  function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [CONV_W-1:0] x);
    logic [CHAN_W-1:0] r;
    if (x < 0) begin
      r = '0;
    end else if (x > CONV_W'(CHAN_MAX)) begin
      r = CHAN_W'(CHAN_MAX);
    end else begin
      r = x[CHAN_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/ycg_if.sv
interface ycg_pixel_if;
  import ycg_pkg::*;
  logic                valid;
  logic                ready;
  logic [LUMA_W-1:0]   luma;
  logic [CHROMA_W-1:0] chroma_v;
  logic [CHROMA_W-1:0] chroma_u;
  modport source(output valid, luma, chroma_v, chroma_u, input ready);
  modport sink(input valid, luma, chroma_v, chroma_u, output ready);
endinterface

interface ycg_cell_if;
  import ycg_pkg::*;
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   cell_row;
  logic [COL_W-1:0]   cell_col;
  logic [LEVEL_W-1:0] glyph_level;
  logic [RGB_W-1:0]   color_rgb;
  logic               frame_done;
  modport source(output valid, cell_row, cell_col, glyph_level, color_rgb, frame_done,
                 input ready);
  modport sink(input valid, cell_row, cell_col, glyph_level, color_rgb, frame_done,
               output ready);
endinterface

interface ycg_cfg_if;
  import ycg_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: design/ycg_div.sv
module ycg_div #(
  parameter int DW = 41,
  parameter int VW = 23
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);
  localparam int NW = $clog2(DW + 1);

  logic          busy;
  logic [NW-1:0] cnt;
  logic [DW-1:0] quo;
  logic [VW-1:0] rem;
  logic [VW:0]   trial;
  logic          ge;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    trial = {rem, quo[DW-1]};
    ge    = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= NW'(DW);
    end else if (busy) begin
      if (cnt != '0) begin
        cnt <= cnt - NW'(1);
      end else begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy && cnt != '0) begin
      quo <= {quo[DW-2:0], ge};
      rem <= ge ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
    end
  end

  assign done      = busy && (cnt == '0);
  assign quotient  = quo;
  assign remainder = rem;

endmodule

FILE: design/ycg_ctrl.sv
module ycg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  ycg_pkg::ycg_status_t status,
  output ycg_pkg::ycg_cmd_t    cmd
);
  import ycg_pkg::*;

  ycg_state_t state, state_next;
  ycg_job_t   job, job_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_DIV_START;
      job   <= JOB_W;
    end else begin
      state <= state_next;
      job   <= job_next;
    end
  end

  always_comb begin
    state_next = state;
    job_next   = job;
    if (status.cfg_restart) begin
      state_next = ST_DIV_START;
      job_next   = JOB_W;
    end else begin
      unique case (state)
        ST_DIV_START: state_next = ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (status.div_done) begin
            unique case (job)
              JOB_W: begin
                job_next   = JOB_H;
                state_next = ST_DIV_START;
              end
              JOB_H: state_next = ST_IDLE;
              JOB_L: begin
                job_next   = JOB_R;
                state_next = ST_DIV_START;
              end
              JOB_R: begin
                job_next   = JOB_G;
                state_next = ST_DIV_START;
              end
              JOB_G: begin
                job_next   = JOB_B;
                state_next = ST_DIV_START;
              end
              JOB_B: state_next = ST_FINISH;
              default: state_next = ST_IDLE;
            endcase
          end
        end
        ST_IDLE: begin
          if (status.in_valid) begin
            state_next = ST_PROD;
          end
        end
        ST_PROD: state_next = ST_MIX;
        ST_MIX:  state_next = ST_ACC;
        ST_ACC: begin
          if (status.emit) begin
            job_next   = JOB_L;
            state_next = ST_DIV_START;
          end else begin
            state_next = ST_IDLE;
          end
        end
        ST_FINISH: begin
          if (status.out_free) begin
            state_next = ST_IDLE;
          end
        end
        default: state_next = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.job         = job;
    cmd.in_ready    = (state == ST_IDLE) && !status.cfg_restart;
    cmd.accept      = cmd.in_ready && status.in_valid;
    cmd.prod        = (state == ST_PROD);
    cmd.mix         = (state == ST_MIX);
    cmd.acc         = (state == ST_ACC);
    cmd.div_start   = (state == ST_DIV_START);
    cmd.div_store   = (state == ST_DIV_WAIT) && status.div_done;
    cmd.finish_load = (state == ST_FINISH) && status.out_free;
  end

  // Idle follows either the end of initialization or the last channel division.
  a_idle_job: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (job == JOB_H || job == JOB_B))
    else $error("idle reached from an unexpected division job");

endmodule

FILE: design/ycg_datapath.sv
module ycg_datapath #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int MAX_COLS   = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  ycg_pixel_if.sink            pixel,
  ycg_cell_if.source           result,
  ycg_cfg_if.sink              cfg,
  input  ycg_pkg::ycg_cmd_t    cmd,
  output ycg_pkg::ycg_status_t status
);
  import ycg_pkg::*;

  localparam int XW   = $clog2(MAX_WIDTH + 1);
  localparam int YW   = $clog2(MAX_HEIGHT + 1);
  localparam int KW   = $clog2(MAX_COLS + 1);
  localparam int CIW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RIW  = $clog2(MAX_HEIGHT);
  localparam int CNTW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int LSW  = LUMA_W + CNTW;
  localparam int SUMW = CHAN_W + CNTW;
  localparam int MW   = LSW + 3 * SUMW + CNTW;

  // Configuration registers.
  logic [11:0] frame_width, frame_height, grid_rows;
  logic [8:0]  grid_cols, glyph_count;
  logic        ansi_mode;

  logic [XW-1:0] eff_w;
  logic [YW-1:0] eff_h;
  logic [KW-1:0] eff_cols;
  logic [YW-1:0] eff_rows;
  logic [8:0]    glyphs;

  always_comb begin
    int lim;
    if (frame_width == '0) begin
      eff_w = XW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      eff_w = XW'(MAX_WIDTH);
    end else begin
      eff_w = XW'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = YW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      eff_h = YW'(MAX_HEIGHT);
    end else begin
      eff_h = YW'(frame_height);
    end
    lim = (32'(eff_w) < MAX_COLS) ? 32'(eff_w) : MAX_COLS;
    if (grid_cols == '0) begin
      eff_cols = KW'(1);
    end else if (32'(grid_cols) > lim) begin
      eff_cols = KW'(lim);
    end else begin
      eff_cols = KW'(grid_cols);
    end
    if (grid_rows == '0) begin
      eff_rows = YW'(1);
    end else if (32'(grid_rows) > 32'(eff_h)) begin
      eff_rows = eff_h;
    end else begin
      eff_rows = YW'(grid_rows);
    end
    glyphs = (32'(glyph_count) > GLYPH_MAX) ? 9'(GLYPH_MAX) : glyph_count;
  end

  logic cfg_restart;
  assign cfg.ready   = 1'b1;
  assign cfg_restart = cfg.valid && (32'(cfg.index) < REG_COUNT);

  // Position and edge tracking.
  logic [XW-1:0]  px, nce, qw;
  logic [YW-1:0]  py, nre, qh;
  logic [CIW-1:0] col;
  logic [RIW-1:0] row;
  logic [KW-1:0]  crem, rw;
  logic [YW-1:0]  rrem, rh;
  logic [MAX_COLS-1:0] vld;

  logic [XW-1:0] px1;
  logic [YW-1:0] py1;
  logic [KW:0]   csum;
  logic          ccarry;
  logic [YW:0]   rsum;
  logic          rcarry;
  logic          col_adv, row_adv, emit;

  always_comb begin
    px1     = px + XW'(1);
    py1     = py + YW'(1);
    csum    = (KW+1)'(crem) + (KW+1)'(rw);
    ccarry  = csum >= (KW+1)'(eff_cols);
    rsum    = (YW+1)'(rrem) + (YW+1)'(rh);
    rcarry  = rsum >= (YW+1)'(eff_rows);
    col_adv = (px1 >= nce) && ((KW+1)'(col) + (KW+1)'(1) < (KW+1)'(eff_cols));
    row_adv = (py1 >= nre) && ((YW+1)'(row) + (YW+1)'(1) < (YW+1)'(eff_rows));
    emit    = (px1 == nce) && (py1 == nre);
  end

  // Divider shared by the edge setup and the cell averages.
  logic [SUMW-1:0] div_a, div_q;
  logic [CNTW-1:0] div_b, div_r;
  logic            div_done;

  logic [LSW-1:0]  sum_l;
  logic [SUMW-1:0] sum_r, sum_g, sum_b;
  logic [CNTW-1:0] sum_n;

  always_comb begin
    unique case (cmd.job)
      JOB_W: begin
        div_a = SUMW'(eff_w);
        div_b = CNTW'(eff_cols);
      end
      JOB_H: begin
        div_a = SUMW'(eff_h);
        div_b = CNTW'(eff_rows);
      end
      JOB_L: begin
        div_a = SUMW'(sum_l);
        div_b = sum_n;
      end
      JOB_R: begin
        div_a = sum_r;
        div_b = sum_n;
      end
      JOB_G: begin
        div_a = sum_g;
        div_b = sum_n;
      end
      default: begin
        div_a = sum_b;
        div_b = sum_n;
      end
    endcase
  end

  ycg_div #(.DW(SUMW), .VW(CNTW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Control state: registers, position, valid bits.
  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      if (rst) begin
        frame_width  <= 12'd640;
        frame_height <= 12'd480;
        grid_rows    <= 12'd48;
        grid_cols    <= 9'd64;
        glyph_count  <= 9'd16;
        ansi_mode    <= 1'b0;
      end else begin
        unique case (ycg_reg_t'(cfg.index))
          REG_FRAME_WIDTH:  frame_width  <= cfg.data;
          REG_FRAME_HEIGHT: frame_height <= cfg.data;
          REG_GRID_ROWS:    grid_rows    <= cfg.data;
          REG_GRID_COLS:    grid_cols    <= cfg.data[8:0];
          REG_GLYPH_COUNT:  glyph_count  <= cfg.data[8:0];
          REG_ANSI_MODE:    ansi_mode    <= cfg.data[0];
          default: ;
        endcase
      end
      px  <= '0;
      py  <= '0;
      col <= '0;
      row <= '0;
      vld <= '0;
    end else begin
      if (cmd.div_store && cmd.job == JOB_W) begin
        qw   <= XW'(div_q);
        rw   <= KW'(div_r);
        nce  <= XW'(div_q);
        crem <= KW'(div_r);
      end
      if (cmd.div_store && cmd.job == JOB_H) begin
        qh   <= YW'(div_q);
        rh   <= YW'(div_r);
        nre  <= YW'(div_q);
        rrem <= YW'(div_r);
      end
      if (cmd.acc) begin
        vld[col] <= !emit;
        if (px1 >= eff_w) begin
          px   <= '0;
          col  <= '0;
          nce  <= qw;
          crem <= rw;
          if (py1 >= eff_h) begin
            py   <= '0;
            row  <= '0;
            nre  <= qh;
            rrem <= rh;
          end else begin
            py <= py1;
            if (row_adv) begin
              row  <= row + RIW'(1);
              nre  <= nre + qh + YW'(rcarry);
              rrem <= YW'(rcarry ? rsum - (YW+1)'(eff_rows) : rsum);
            end
          end
        end else begin
          px <= px1;
          if (col_adv) begin
            col  <= col + CIW'(1);
            nce  <= nce + qw + XW'(ccarry);
            crem <= KW'(ccarry ? csum - (KW+1)'(eff_cols) : csum);
          end
        end
      end
    end
  end

  // Accumulator memory, one word per cell column.
  logic [MW-1:0] mem [MAX_COLS];
  logic [MW-1:0] rd_word, new_word;
  logic          rd_vld;

  logic [LUMA_W-1:0]   lum_q;
  logic [CHROMA_W-1:0] cv_q, cu_q;
  logic signed [CONV_W-1:0] p_y, p_rv, p_gv, p_gu, p_bu;
  logic [CHAN_W-1:0]   ch_r, ch_g, ch_b;

  logic [LSW-1:0]  old_l, new_l;
  logic [SUMW-1:0] old_r, old_g, old_b, new_r, new_g, new_b;
  logic [CNTW-1:0] old_n, new_n;

  always_comb begin
    if (rd_vld) begin
      {old_l, old_r, old_g, old_b, old_n} = rd_word;
    end else begin
      {old_l, old_r, old_g, old_b, old_n} = '0;
    end
    new_l    = old_l + LSW'(lum_q);
    new_r    = old_r + SUMW'(ch_r);
    new_g    = old_g + SUMW'(ch_g);
    new_b    = old_b + SUMW'(ch_b);
    new_n    = old_n + CNTW'(1);
    new_word = {new_l, new_r, new_g, new_b, new_n};
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_word <= mem[col];
      rd_vld  <= vld[col];
    end
    if (cmd.acc && !emit) begin
      mem[col] <= new_word;
    end
  end

  logic [LUMA_W-1:0]     yy;
  logic signed [9:0]     v_s, u_s;

  always_comb begin
    yy  = (lum_q < LUMA_W'(Y_OFFSET)) ? '0 : lum_q - LUMA_W'(Y_OFFSET);
    v_s = $signed({2'b00, cv_q}) - 10'sd128;
    u_s = $signed({2'b00, cu_q}) - 10'sd128;
  end

  logic [LUMA_W-1:0]  al;
  logic [CHAN_W-1:0]  ar, ag, ab;
  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;
  logic               done_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lum_q <= pixel.luma;
      cv_q  <= pixel.chroma_v;
      cu_q  <= pixel.chroma_u;
    end
    if (cmd.prod) begin
      p_y  <= CONV_W'($signed({1'b0, yy}) * K_Y);
      p_rv <= CONV_W'(v_s * K_RV);
      p_gv <= CONV_W'(v_s * K_GV);
      p_gu <= CONV_W'(u_s * K_GU);
      p_bu <= CONV_W'(u_s * K_BU);
    end
    if (cmd.mix) begin
      ch_r <= clamp_chan(p_y + p_rv);
      ch_g <= clamp_chan(p_y - p_gv - p_gu);
      ch_b <= clamp_chan(p_y + p_bu);
    end
    if (cmd.acc) begin
      sum_l  <= new_l;
      sum_r  <= new_r;
      sum_g  <= new_g;
      sum_b  <= new_b;
      sum_n  <= new_n;
      row_q  <= ROW_W'(row);
      col_q  <= COL_W'(col);
      done_q <= (px1 == eff_w) && (py1 == eff_h);
    end
    if (cmd.div_store) begin
      unique case (cmd.job)
        JOB_L:   al <= LUMA_W'(div_q);
        JOB_R:   ar <= CHAN_W'(div_q);
        JOB_G:   ag <= CHAN_W'(div_q);
        JOB_B:   ab <= CHAN_W'(div_q);
        default: ;
      endcase
    end
  end

  // Result: glyph level and color, with optional saturation per channel.
  logic [CHAN_W-1:0]   mx, thr, fr, fg, fb;
  logic [CHAN_W+2:0]   mx7;
  logic [LEVEL_W+8:0]  lvl_prod;

  always_comb begin
    mx  = (ar > ag) ? ar : ag;
    mx  = (ab > mx) ? ab : mx;
    mx7 = ((CHAN_W+3)'(mx) << 3) - (CHAN_W+3)'(mx);
    thr = CHAN_W'(mx7 >> 3);
    if (ansi_mode && mx != '0) begin
      fr = (ar >= thr) ? CHAN_W'(CHAN_MAX) : '0;
      fg = (ag >= thr) ? CHAN_W'(CHAN_MAX) : '0;
      fb = (ab >= thr) ? CHAN_W'(CHAN_MAX) : '0;
    end else begin
      fr = ar;
      fg = ag;
      fb = ab;
    end
    lvl_prod = (LEVEL_W+9)'(al) * (LEVEL_W+9)'(glyphs);
  end

  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_load) begin
      result.cell_row    <= row_q;
      result.cell_col    <= col_q;
      result.glyph_level <= LEVEL_W'(lvl_prod >> 8);
      result.color_rgb   <= {fr[CHAN_W-1:10], fg[CHAN_W-1:10], fb[CHAN_W-1:10]};
      result.frame_done  <= done_q;
    end
  end

  assign result.valid = out_valid;
  assign pixel.ready  = cmd.in_ready;

  always_comb begin
    status.in_valid    = pixel.valid;
    status.cfg_restart = cfg_restart;
    status.emit        = emit;
    status.div_done    = div_done;
    status.out_free    = !out_valid || result.ready;
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (KW+1)'(col) < (KW+1)'(eff_cols))
    else $error("cell column beyond grid");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (YW+1)'(row) < (YW+1)'(eff_rows))
    else $error("cell row beyond grid");

  a_px_range: assert property (@(posedge clk) disable iff (rst)
    (px < eff_w) && (py < eff_h))
    else $error("pixel position outside frame");

endmodule

FILE: design/yuv_cell_glyph_and_color.sv
// Averages a raster-order YUV pixel stream over a grid of cells and returns one
// result per cell: its grid position, a glyph level (average luma times the
// glyph count over 256) and an 8-bit-per-channel RGB color, optionally
// saturated per channel. Each pixel passes through memory read, products,
// clamp and accumulate steps. A pixel that closes a cell adds four passes of
// the shared one-bit-per-cycle divider and then loads the output register; a
// finished result may wait there while the next pixel is taken. After reset
// and after every register write the block spends two divider passes
// computing the cell edge steps and accepts no pixel during that time.
module yuv_cell_glyph_and_color #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int MAX_COLS   = 256
) (
  input  logic        clk,
  input  logic        rst,
  ycg_pixel_if.sink   pixel,
  ycg_cell_if.source  result,
  ycg_cfg_if.sink     cfg
);
  import ycg_pkg::*;

  ycg_cmd_t    cmd;
  ycg_status_t status;

  ycg_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  ycg_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_COLS   (MAX_COLS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel),
    .result (result),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status)
  );

endmodule

FILE: tb/sv/ycg_cell_checker.sv
`timescale 1ns / 1ps
module ycg_cell_checker
  import ycg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ycg_pixel_if pix,
  ycg_cell_if  cel,
  ycg_cfg_if   cfgc,
  output int   errors,
  output int   due,
  output int   cells_seen
);

  localparam int unsigned WMAX = 2048;
  localparam int unsigned HMAX = 2048;
  localparam int unsigned CMAX_COLS = 256;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [LEVEL_W-1:0] level;
    logic [RGB_W-1:0]   rgb;
    logic               done;
  } cell_t;

  logic [11:0] frame_w, frame_h, rows_cfg;
  logic [8:0]  cols_cfg, glyphs_cfg;
  logic        ansi_on;

  longint unsigned luma_acc[CMAX_COLS];
  longint unsigned red_acc[CMAX_COLS];
  longint unsigned grn_acc[CMAX_COLS];
  longint unsigned blu_acc[CMAX_COLS];
  int unsigned     hits_acc[CMAX_COLS];
  int unsigned     px, py, col_idx, row_idx, col_edge, row_edge;
  cell_t           cells_due[$];
  int              err_count = 0;
  int              cell_count = 0;

  function automatic int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned used_w();
    return sat(frame_w, 1, WMAX);
  endfunction

  function automatic int unsigned used_h();
    return sat(frame_h, 1, HMAX);
  endfunction

  function automatic int unsigned used_cols();
    return sat(cols_cfg, 1, (used_w() < CMAX_COLS) ? used_w() : CMAX_COLS);
  endfunction

  function automatic int unsigned used_rows();
    return sat(rows_cfg, 1, used_h());
  endfunction

  function automatic int unsigned cut(int unsigned size, int unsigned k, int unsigned n);
    return int'((longint'(size) * k) / n);
  endfunction

  function automatic longint unsigned to_chan(int x);
    if (x < 0) return 0;
    if (x > CHAN_MAX) return CHAN_MAX;
    return x;
  endfunction

  task automatic restart_frame();
    for (int i = 0; i < CMAX_COLS; i++) begin
      luma_acc[i] = 0;
      red_acc[i]  = 0;
      grn_acc[i]  = 0;
      blu_acc[i]  = 0;
      hits_acc[i] = 0;
    end
    px = 0;
    py = 0;
    col_idx = 0;
    row_idx = 0;
    col_edge = cut(used_w(), 1, used_cols());
    row_edge = cut(used_h(), 1, used_rows());
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
    case (idx)
      REG_FRAME_WIDTH:  frame_w = d;
      REG_FRAME_HEIGHT: frame_h = d;
      REG_GRID_ROWS:    rows_cfg = d;
      REG_GRID_COLS:    cols_cfg = d[8:0];
      REG_GLYPH_COUNT:  glyphs_cfg = d[8:0];
      REG_ANSI_MODE:    ansi_on = d[0];
      default:          return;
    endcase
    restart_frame();
  endtask

  task automatic average_pixel(logic [7:0] y, logic [7:0] cv, logic [7:0] cu);
    int unsigned     w, h, gc, gr, glyphs, ci;
    int              yy, v, u;
    longint unsigned n, al, ar, ag, ab, m, t;
    cell_t           c;
    w = used_w();
    h = used_h();
    gc = used_cols();
    gr = used_rows();
    glyphs = (glyphs_cfg > GLYPH_MAX) ? GLYPH_MAX : glyphs_cfg;
    ci = (col_idx < CMAX_COLS) ? col_idx : CMAX_COLS - 1;
    yy = (y < Y_OFFSET) ? 0 : int'(y) - Y_OFFSET;
    v = int'(cv) - C_OFFSET;
    u = int'(cu) - C_OFFSET;
    luma_acc[ci] += y;
    red_acc[ci]  += to_chan(K_Y * yy + K_RV * v);
    grn_acc[ci]  += to_chan(K_Y * yy - K_GV * v - K_GU * u);
    blu_acc[ci]  += to_chan(K_Y * yy + K_BU * u);
    hits_acc[ci] += 1;
    if (px + 1 == col_edge && py + 1 == row_edge) begin
      n  = hits_acc[ci];
      al = luma_acc[ci] / n;
      ar = red_acc[ci] / n;
      ag = grn_acc[ci] / n;
      ab = blu_acc[ci] / n;
      if (ansi_on) begin
        m = (ar > ag) ? ar : ag;
        if (ab > m) m = ab;
        if (m > 0) begin
          t  = (m * 7) >> 3;
          ar = (ar >= t) ? CHAN_MAX : 0;
          ag = (ag >= t) ? CHAN_MAX : 0;
          ab = (ab >= t) ? CHAN_MAX : 0;
        end
      end
      c.row   = row_idx[ROW_W-1:0];
      c.col   = col_idx[COL_W-1:0];
      c.level = 8'((al * glyphs) / 256);
      c.rgb   = {8'(ar >> 10), 8'(ag >> 10), 8'(ab >> 10)};
      c.done  = (px + 1 == w && py + 1 == h);
      cells_due.push_back(c);
      luma_acc[ci] = 0;
      red_acc[ci]  = 0;
      grn_acc[ci]  = 0;
      blu_acc[ci]  = 0;
      hits_acc[ci] = 0;
    end
    px++;
    if (px >= col_edge && col_idx + 1 < gc) begin
      col_idx++;
      col_edge = cut(w, col_idx + 1, gc);
    end
    if (px >= w) begin
      px = 0;
      col_idx = 0;
      col_edge = cut(w, 1, gc);
      py++;
      if (py >= row_edge && row_idx + 1 < gr) begin
        row_idx++;
        row_edge = cut(h, row_idx + 1, gr);
      end
      if (py >= h) begin
        py = 0;
        row_idx = 0;
        row_edge = cut(h, 1, gr);
      end
    end
  endtask

  task automatic compare_cell();
    cell_t c;
    cell_count++;
    if (cells_due.size() == 0) begin
      $error("cell result with nothing expected: row %0d col %0d",
             cel.cell_row, cel.cell_col);
      err_count++;
      return;
    end
    c = cells_due.pop_front();
    if (cel.cell_row !== c.row) begin
      $error("cell_row: expected %0d, got %0d", c.row, cel.cell_row);
      err_count++;
    end
    if (cel.cell_col !== c.col) begin
      $error("cell_col: expected %0d, got %0d", c.col, cel.cell_col);
      err_count++;
    end
    if (cel.glyph_level !== c.level) begin
      $error("glyph_level: expected %0d, got %0d", c.level, cel.glyph_level);
      err_count++;
    end
    if (cel.color_rgb !== c.rgb) begin
      $error("color_rgb: expected %06h, got %06h", c.rgb, cel.color_rgb);
      err_count++;
    end
    if (cel.frame_done !== c.done) begin
      $error("frame_done: expected %0d, got %0d", c.done, cel.frame_done);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_w = 640;
      frame_h = 480;
      rows_cfg = 48;
      cols_cfg = 64;
      glyphs_cfg = 16;
      ansi_on = 1'b0;
      restart_frame();
      cells_due.delete();
    end else begin
      if (cfgc.valid && cfgc.ready) write_reg(cfgc.index, cfgc.data);
      if (pix.valid && pix.ready) average_pixel(pix.luma, pix.chroma_v, pix.chroma_u);
      if (cel.valid && cel.ready) compare_cell();
    end
    errors <= err_count;
    due <= cells_due.size();
    cells_seen <= cell_count;
  end

endmodule

FILE: tb/sv/tb_yuv_cell_glyph_and_color.sv
`timescale 1ns / 1ps
module tb_yuv_cell_glyph_and_color;
  import ycg_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst;
  int   errors, due, cells_seen;
  int   pixels_sent = 0;
  int   settings = 0;
  int   quiet = 0;
  int   stall_left = 0;
  int   calm_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  logic calm_sender = 1'b0;

  always #5 clk = ~clk;

  ycg_pixel_if pix();
  ycg_cell_if  cel();
  ycg_cfg_if   cfgc();

  yuv_cell_glyph_and_color u_top (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix),
    .result (cel),
    .cfg    (cfgc)
  );

  ycg_cell_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .pix        (pix),
    .cel        (cel),
    .cfgc       (cfgc),
    .errors     (errors),
    .due        (due),
    .cells_seen (cells_seen)
  );

  // Result side: random stalls, calm stretches, and one long hold-off on request.
  always @(posedge clk) begin
    int r;
    if (rst) begin
      cel.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      cel.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      stall_left = HOLD_CYCLES;
      cel.ready <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left--;
      cel.ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        stall_left = $urandom_range(10, 60);
        cel.ready <= 1'b0;
      end else if (r < 6) begin
        calm_left = $urandom_range(50, 150);
        cel.ready <= 1'b1;
      end else begin
        cel.ready <= (r >= 25);
      end
    end
  end

  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (cel.valid && cel.ready) || (cfgc.valid && cfgc.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("yuv_cell_glyph_and_color test failed");
      $finish;
    end
  end

  function automatic int pixel_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_sender || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic push_pixel(logic [7:0] y, logic [7:0] v, logic [7:0] u);
    int gap;
    gap = pixel_gap();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.luma <= y;
    pix.chroma_v <= v;
    pix.chroma_u <= u;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++)
      push_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
  endtask

  // A pixel that closes no cell may still be in flight, so wait out the latency too.
  task automatic settle();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
    cfgc.valid <= 1'b1;
    cfgc.index <= idx;
    cfgc.data <= d;
    @(posedge clk);
    while (!cfgc.ready) @(posedge clk);
  endtask

  task automatic configure(int w, int h, int rows, int cols, int glyphs, int ansi);
    settle();
    write_reg(REG_FRAME_WIDTH, CFG_DW'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DW'(h));
    write_reg(REG_GRID_ROWS, CFG_DW'(rows));
    write_reg(REG_GRID_COLS, CFG_DW'(cols));
    write_reg(REG_GLYPH_COUNT, CFG_DW'(glyphs));
    write_reg(REG_ANSI_MODE, CFG_DW'(ansi));
    // Indexes past the register list must be ignored without a restart.
    if ($urandom_range(0, 1))
      write_reg(CFG_IW'(REG_COUNT) + CFG_IW'($urandom_range(0, 1)),
                CFG_DW'($urandom_range(0, 4095)));
    cfgc.valid <= 1'b0;
    settings++;
  endtask

  initial begin
    int w, h;
    rst = 1'b1;
    pix.valid <= 1'b0;
    pix.luma <= '0;
    pix.chroma_v <= '0;
    pix.chroma_u <= '0;
    cfgc.valid <= 1'b0;
    cfgc.index <= '0;
    cfgc.data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default geometry: a few pixels that complete no cell.
    push_random(8);

    // 2x2 frame, one cell: extremes of luma and chroma, clamping at both ends.
    configure(2, 2, 1, 1, 256, 0);
    for (int i = 0; i < 4; i++) push_pixel(8'd255, 8'd255, 8'd255);
    for (int i = 0; i < 4; i++) push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd16, 8'd128, 8'd128);
    push_pixel(8'd15, 8'd128, 8'd128);
    push_pixel(8'd17, 8'd255, 8'd0);
    push_pixel(8'd235, 8'd0, 8'd255);
    push_pixel(8'd255, 8'd0, 8'd0);
    push_pixel(8'd0, 8'd255, 8'd255);
    push_pixel(8'd128, 8'd128, 8'd0);
    push_pixel(8'd128, 8'd0, 8'd128);

    // Zero-sized frame and grid saturate to one pixel; glyph count zero; ANSI on,
    // including a black cell whose channels stay untouched.
    configure(0, 0, 0, 0, 0, 1);
    push_pixel(8'd16, 8'd128, 8'd128);
    push_pixel(8'd255, 8'd255, 8'd0);
    push_pixel(8'd128, 8'd0, 8'd255);
    push_pixel(8'd200, 8'd200, 8'd200);
    push_pixel(8'd255, 8'd128, 8'd128);

    // Oversized registers: width and rows saturate, 256 columns, glyphs above 256.
    configure(4095, 1, 4095, 511, 511, 1);
    push_random(120);

    // Every pixel closes a cell while the result side holds off.
    configure(3, 2, 2, 3, 255, 0);
    calm_sender = 1'b1;
    hold_req = 1'b1;
    push_random(60);
    calm_sender = 1'b0;

    for (int p = 0; p < 5; p++) begin
      w = $urandom_range(1, 24);
      h = $urandom_range(1, 12);
      configure(w, h, $urandom_range(0, h + 2), $urandom_range(0, w + 2),
                $urandom_range(0, 300), $urandom_range(0, 1));
      calm_sender = ($urandom_range(0, 3) == 0);
      push_random((w * h * 2 < 50) ? w * h * 2 : 50);
    end

    pix.valid <= 1'b0;
    @(posedge clk);
    while (due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixels under %0d register settings; %0d cell results compared.",
             pixels_sent, settings, cells_seen);
    if (errors == 0 && due == 0) begin
      $display("yuv_cell_glyph_and_color test passed");
    end else begin
      $display("yuv_cell_glyph_and_color test failed");
    end
    $finish;
  end

endmodule
